### rtl/imm_pkg.sv
`timescale 1ns / 1ps
// imm_pkg: shared types, constants and the microprogram of the integer matrix multiplier
// no dependencies; used by integer_matrix_multiply_core
package imm_pkg;

  localparam int CFG_W    = 4;   // width of one size register
  localparam int NUM_CFG  = 4;
  localparam int CFG_AW   = 2;
  localparam int PROD_W   = 35;
  localparam int POS_OUT_W = 3;  // row and column fields
  localparam int OP_W     = 2;

  typedef enum logic [CFG_AW-1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } reg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // microprogram step addresses
  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_CHECK = 4'd1,
    S_ELEM  = 4'd2,
    S_READ  = 4'd3,
    S_MUL   = 4'd4,
    S_ACC   = 4'd5,
    S_EMIT  = 4'd6,
    S_STEP  = 4'd7,
    S_ERR   = 4'd8
  } upc_t;

  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_ALWAYS      = 3'd1,
    C_NOT_COMPUTE = 3'd2,
    C_MISMATCH    = 3'd3,
    C_K_MORE      = 3'd4,
    C_ELEM_LAST   = 3'd5
  } cond_t;

  typedef struct packed {
    logic  accept;     // input channel open
    logic  init_run;   // clear row and column walk
    logic  init_elem;  // clear sum, set addresses for one element
    logic  mul_en;     // register the product of the read pair
    logic  acc_en;     // add product, step k and addresses
    logic  emit_prod;  // load a product result and step the element
    logic  emit_err;   // load the mismatch result
    logic  wait_out;   // hold here until the output register is free
    cond_t cond;
    upc_t  target;
  } uword_t;

  function automatic uword_t imm_ucode(input upc_t step);
    uword_t w;
    w = '0;
    w.cond = C_NEVER;
    w.target = S_IDLE;
    case (step)
      S_IDLE: begin
        w.accept = 1'b1;
        w.cond = C_NOT_COMPUTE;
        w.target = S_IDLE;
      end
      S_CHECK: begin
        w.init_run = 1'b1;
        w.cond = C_MISMATCH;
        w.target = S_ERR;
      end
      S_ELEM: w.init_elem = 1'b1;
      S_READ: w.cond = C_NEVER;
      S_MUL: w.mul_en = 1'b1;
      S_ACC: begin
        w.acc_en = 1'b1;
        w.cond = C_K_MORE;
        w.target = S_READ;
      end
      S_EMIT: begin
        w.emit_prod = 1'b1;
        w.wait_out = 1'b1;
        w.cond = C_ELEM_LAST;
        w.target = S_IDLE;
      end
      S_STEP: begin
        w.cond = C_ALWAYS;
        w.target = S_ELEM;
      end
      S_ERR: begin
        w.emit_err = 1'b1;
        w.wait_out = 1'b1;
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // zero counts as one, anything above the limit as the limit
  function automatic logic [CFG_W-1:0] imm_dim(input logic [CFG_W-1:0] v,
                                               input logic [CFG_W-1:0] maxd);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > maxd) r = maxd;
    return r;
  endfunction

endpackage

### rtl/integer_matrix_multiply_core.sv
`timescale 1ns / 1ps
// integer_matrix_multiply_core: signed matrix product driven by a microcoded sequencer
// depends on imm_pkg and imm_ram
//
// usage
// - cfg_we/cfg_addr/cfg_wdata set rows_a, cols_a, rows_b, cols_b (index 0..3), only while idle
// - s_tuser holds the operation, s_tdata the element; load A and load B items each
//   write the next element of that matrix in row-major order
// - a compute item checks cols_a against rows_b; on a mismatch one item comes out with
//   m_tuser set, else rows_a x cols_b products in row-major order, the last with m_tlast
// - sequence: after a compute item is accepted the check step runs; a mismatch result is
//   loaded at the error step, else a product run walks the read, multiply and add steps
//   of the shared multiplier for each term; s_tready is low meanwhile
// - results sit in one output register; a stall on m_tready holds the sequencer at its emit
//   or error step, and the input side stays open for loads while a last result waits
// - reset clears the size registers to 1, both load positions to 0 and the output valid
//   flag; matrix stores keep no reset value
module integer_matrix_multiply_core
  import imm_pkg::*;
#(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [CFG_AW-1:0]                     cfg_addr,
  input  logic [CFG_W-1:0]                      cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((ELEM_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // element
  input  logic [OP_W-1:0]                       s_tuser,  // operation
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [47:0]                           m_tdata,  // product, row, column, zero fill
  output logic                                  m_tuser,  // status
  output logic                                  m_tlast
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int IW    = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
  localparam int SW    = AW > CFG_W ? AW : CFG_W;
  localparam int MW    = 2 * ELEM_BITS;
  localparam int XW    = MW > PROD_W ? MW : PROD_W;
  localparam int TD_W  = 48;
  localparam logic [CFG_W-1:0] MAXD = CFG_W'(MAX_DIM);

  logic [CFG_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [CFG_W-1:0] ra, ca, rb, cb;
  logic [PW-1:0]    pos_a, pos_b;
  upc_t             upc, upc_next;
  uword_t           uw;
  op_t              s_op;
  logic             in_acc, slot_free, stall, take;
  logic             k_last, j_last, elem_last;
  logic [IW-1:0]    i_cnt, j_cnt, k_cnt;
  logic [AW-1:0]    row_base, addr_a, addr_b;
  logic             we_a, we_b;
  logic signed [ELEM_BITS-1:0] rd_a, rd_b;
  logic signed [MW-1:0]        prod;
  logic [PROD_W-1:0]           acc, prod_ext;
  logic [PROD_W-1:0]           out_prod;
  logic [POS_OUT_W-1:0]        out_row, out_col;
  logic                        out_status, out_last;
  logic                        do_emit_prod, do_emit_err;

  assign s_op = op_t'(s_tuser);
  assign ra = imm_dim(rows_a, MAXD);
  assign ca = imm_dim(cols_a, MAXD);
  assign rb = imm_dim(rows_b, MAXD);
  assign cb = imm_dim(cols_b, MAXD);

  assign k_last    = (CFG_W'(k_cnt) + CFG_W'(1)) == ca;
  assign j_last    = (CFG_W'(j_cnt) + CFG_W'(1)) == cb;
  assign elem_last = j_last && ((CFG_W'(i_cnt) + CFG_W'(1)) == ra);
  assign slot_free = !m_tvalid || m_tready;

  // control word decode
  always_comb begin
    uw = imm_ucode(upc);
    stall = uw.wait_out && !slot_free;
    s_tready = uw.accept;
    in_acc = s_tvalid && uw.accept;
    we_a = in_acc && s_op == OP_LOAD_A && pos_a < PW'(DEPTH);
    we_b = in_acc && s_op == OP_LOAD_B && pos_b < PW'(DEPTH);
    do_emit_prod = uw.emit_prod && !stall;
    do_emit_err = uw.emit_err && !stall;
  end

  // sequencer next step
  always_comb begin
    case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NOT_COMPUTE: take = !(s_tvalid && s_op == OP_COMPUTE);
      C_MISMATCH:    take = ca != rb;
      C_K_MORE:      take = !k_last;
      C_ELEM_LAST:   take = elem_last;
      default:       take = 1'b0;
    endcase
    if (stall) upc_next = upc;
    else if (take) upc_next = uw.target;
    else upc_next = upc_t'(upc + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
      rows_a <= CFG_W'(1);
      cols_a <= CFG_W'(1);
      rows_b <= CFG_W'(1);
      cols_b <= CFG_W'(1);
      pos_a <= '0;
      pos_b <= '0;
    end else begin
      upc <= upc_next;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_ROWS_A: rows_a <= cfg_wdata;
          REG_COLS_A: cols_a <= cfg_wdata;
          REG_ROWS_B: rows_b <= cfg_wdata;
          REG_COLS_B: cols_b <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc && s_op == OP_COMPUTE) begin
        pos_a <= '0;
        pos_b <= '0;
      end else begin
        if (we_a) pos_a <= pos_a + PW'(1);
        if (we_b) pos_b <= pos_b + PW'(1);
      end
    end
  end

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (pos_a[AW-1:0]),
    .wdata (s_tdata[ELEM_BITS-1:0]),
    .raddr (addr_a),
    .rdata (rd_a)
  );

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (pos_b[AW-1:0]),
    .wdata (s_tdata[ELEM_BITS-1:0]),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  assign prod_ext = PROD_W'(XW'(prod));

  // datapath
  always_ff @(posedge clk) begin
    if (uw.init_run) begin
      i_cnt <= '0;
      j_cnt <= '0;
      row_base <= '0;
    end
    if (uw.init_elem) begin
      k_cnt <= '0;
      acc <= '0;
      addr_a <= row_base;
      addr_b <= AW'(j_cnt);
    end
    if (uw.mul_en) begin
      prod <= rd_a * rd_b;
    end
    if (uw.acc_en) begin
      acc <= acc + prod_ext;
      k_cnt <= k_cnt + IW'(1);
      addr_a <= addr_a + AW'(1);
      addr_b <= AW'(SW'(addr_b) + SW'(cb));
    end
    if (do_emit_prod) begin
      if (j_last) begin
        j_cnt <= '0;
        i_cnt <= i_cnt + IW'(1);
        row_base <= AW'(SW'(row_base) + SW'(ca));
      end else begin
        j_cnt <= j_cnt + IW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_emit_prod || do_emit_err) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit_prod) begin
      out_prod <= acc;
      out_row <= POS_OUT_W'(i_cnt);
      out_col <= POS_OUT_W'(j_cnt);
      out_status <= 1'b0;
      out_last <= elem_last;
    end else if (do_emit_err) begin
      out_prod <= '0;
      out_row <= '0;
      out_col <= '0;
      out_status <= 1'b1;
      out_last <= 1'b1;
    end
  end

  assign m_tdata = {(TD_W - PROD_W - 2 * POS_OUT_W)'(0), out_col, out_row, out_prod};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("mismatch result without last");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos_a <= PW'(DEPTH) && pos_b <= PW'(DEPTH))
    else $error("load position beyond store depth");

  a_run_clears_pos: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_op == OP_COMPUTE |=> pos_a == '0 && pos_b == '0)
    else $error("load positions not cleared by compute");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    upc == S_ACC |-> CFG_W'(k_cnt) < ca)
    else $error("term index beyond inner dimension");

endmodule

### rtl/imm_ram.sv
`timescale 1ns / 1ps
// imm_ram: generic single write port, single read port ram with registered read
// no dependencies
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
